// File: design/bary_pkg.sv
`default_nettype none
package bary_pkg;
   localparam int CoordWidth = 16;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int EdgeWidth  = 2 * DiffWidth + 1;
   localparam int MagWidth   = EdgeWidth;
   // numerator magnitude shifted by 17 plus denominator
   localparam int NumWidth   = MagWidth + 18;
   localparam int QuoWidth   = NumWidth;
   localparam int RemWidth   = MagWidth + 2;
   localparam int NumCells   = NumWidth;
   localparam int WeightWidth = 32;
   localparam int RegIdxWidth = 3;

   localparam logic [RegIdxWidth-1:0] REG_CENTER_X = 3'd0;
   localparam logic [RegIdxWidth-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [RegIdxWidth-1:0] REG_LEFT_X   = 3'd2;
   localparam logic [RegIdxWidth-1:0] REG_LEFT_Y   = 3'd3;
   localparam logic [RegIdxWidth-1:0] REG_RIGHT_X  = 3'd4;
   localparam logic [RegIdxWidth-1:0] REG_RIGHT_Y  = 3'd5;

   // one division lane as it travels down the chain
   typedef struct packed {
      logic [NumWidth-1:0] num;
      logic [RemWidth-1:0] rem;
      logic [QuoWidth-1:0] quo;
      logic [RemWidth-1:0] den2;
      logic                neg;
   } lane_type;

   // per-item payload carried alongside the lanes
   typedef struct packed {
      logic valid;
      logic degen;
   } tag_type;
endpackage
`default_nettype wire

// File: design/barycentric_2d_edge_function.sv
`default_nettype none
// Barycentric weights of a 2D point against the triangle held in the csr_
// registers. One point is taken every clock; the result word appears on
// rsp_ with rsp_valid high once it has passed the front product and lane
// registers, the bit-per-cell chain of divider cells and the output register.
// The receiver cannot stall: every word must be taken in its cycle.
// Write the vertices only while no point is in flight.
module barycentric_2d_edge_function
   import bary_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [CoordWidth-1:0]  req_point_x,
   input  wire logic signed [CoordWidth-1:0]  req_point_y,
   output logic                               rsp_valid,
   output logic signed [WeightWidth-1:0]      rsp_weight_opposite,
   output logic signed [WeightWidth-1:0]      rsp_weight_left,
   output logic signed [WeightWidth-1:0]      rsp_weight_right,
   output logic                               rsp_degenerate,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [RegIdxWidth-1:0]        csr_index,
   input  wire logic [CoordWidth-1:0]         csr_data
);
   logic signed [CoordWidth-1:0] cx_ff, cy_ff, lx_ff, ly_ff, rx_ff, ry_ff;
   lane_type left_c [NumCells+1];
   lane_type right_c [NumCells+1];
   tag_type  tag_c [NumCells+1];
   logic [WeightWidth-1:0] wl, wr;
   logic signed [WeightWidth+1:0] wo;
   logic valid_ff, degen_ff;
   logic signed [WeightWidth-1:0] wo_ff, wl_ff, wr_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // hold the vertex registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; lx_ff <= '0;
         ly_ff <= '0; rx_ff <= '0; ry_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CENTER_X: cx_ff <= csr_data;
            REG_CENTER_Y: cy_ff <= csr_data;
            REG_LEFT_X:   lx_ff <= csr_data;
            REG_LEFT_Y:   ly_ff <= csr_data;
            REG_RIGHT_X:  rx_ff <= csr_data;
            REG_RIGHT_Y:  ry_ff <= csr_data;
            default: ;
         endcase
      end
   end

   bary_front u_front (
      .clock(clock), .reset(reset), .go(start),
      .px(req_point_x), .py(req_point_y),
      .cx(cx_ff), .cy(cy_ff), .lx(lx_ff), .ly(ly_ff), .rx(rx_ff), .ry(ry_ff),
      .left_out(left_c[0]), .right_out(right_c[0]), .tag_out(tag_c[0])
   );

   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      bary_cell u_cell (
         .clock(clock), .reset(reset),
         .left_in(left_c[g]), .right_in(right_c[g]), .tag_in(tag_c[g]),
         .left_out(left_c[g+1]), .right_out(right_c[g+1]), .tag_out(tag_c[g+1])
      );
   end

   // saturate a quotient magnitude with its sign
   function automatic logic [WeightWidth-1:0] sat_q(input logic [QuoWidth-1:0] q,
                                                     input logic neg);
      logic [WeightWidth-1:0] mag;
      if (q > QuoWidth'(32'h8000_0000)) mag = 32'h8000_0000;
      else mag = q[WeightWidth-1:0];
      if (!neg && mag[WeightWidth-1]) mag = 32'h7FFF_FFFF;
      return neg ? -mag : mag;
   endfunction

   always_comb begin
      wl = sat_q(left_c[NumCells].quo, left_c[NumCells].neg);
      wr = sat_q(right_c[NumCells].quo, right_c[NumCells].neg);
      wo = (WeightWidth+2)'(32'sd65536) - (WeightWidth+2)'(signed'(wl))
           - (WeightWidth+2)'(signed'(wr));
   end

   // drop the word onto the result ports
   always_ff @(posedge clock) begin
      if (tag_c[NumCells].degen) begin
         wl_ff <= '0; wr_ff <= '0; wo_ff <= '0;
      end else begin
         wl_ff <= wl;
         wr_ff <= wr;
         if (wo > (WeightWidth+2)'(32'sh7FFF_FFFF)) wo_ff <= 32'h7FFF_FFFF;
         else if (wo < -(WeightWidth+2)'(33'sh0_8000_0000)) wo_ff <= 32'h8000_0000;
         else wo_ff <= wo[WeightWidth-1:0];
      end
      degen_ff <= tag_c[NumCells].degen;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tag_c[NumCells].valid;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_weight_opposite = wo_ff;
   assign rsp_weight_left     = wl_ff;
   assign rsp_weight_right    = wr_ff;
   assign rsp_degenerate      = degen_ff;
endmodule
`default_nettype wire

// File: design/bary_cell.sv
`default_nettype none
module bary_cell
   import bary_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire lane_type left_in,
   input  wire lane_type right_in,
   input  wire tag_type  tag_in,
   output lane_type      left_out,
   output lane_type      right_out,
   output tag_type       tag_out
);
   lane_type left_ff, left_in_n, right_ff, right_in_n;
   tag_type  tag_ff;

   // one restoring step per lane
   function automatic lane_type step(input lane_type a);
      lane_type r;
      logic [RemWidth-1:0] t;
      r = a;
      t = {a.rem[RemWidth-2:0], a.num[NumWidth-1]};
      r.num = {a.num[NumWidth-2:0], 1'b0};
      if (t >= a.den2) begin
         r.rem = t - a.den2;
         r.quo = {a.quo[QuoWidth-2:0], 1'b1};
      end else begin
         r.rem = t;
         r.quo = {a.quo[QuoWidth-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      left_in_n  = step(left_in);
      right_in_n = step(right_in);
   end

   // advance the word one cell
   always_ff @(posedge clock) begin
      left_ff  <= left_in_n;
      right_ff <= right_in_n;
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   assign left_out  = left_ff;
   assign right_out = right_ff;
   assign tag_out   = tag_ff;
endmodule
`default_nettype wire

// File: design/bary_front.sv
`default_nettype none
module bary_front
   import bary_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         go,
   input  wire logic signed [CoordWidth-1:0] px,
   input  wire logic signed [CoordWidth-1:0] py,
   input  wire logic signed [CoordWidth-1:0] cx,
   input  wire logic signed [CoordWidth-1:0] cy,
   input  wire logic signed [CoordWidth-1:0] lx,
   input  wire logic signed [CoordWidth-1:0] ly,
   input  wire logic signed [CoordWidth-1:0] rx,
   input  wire logic signed [CoordWidth-1:0] ry,
   output lane_type                          left_out,
   output lane_type                          right_out,
   output tag_type                           tag_out
);
   // stage 1: products
   logic signed [2*DiffWidth-1:0] pl0_ff, pl1_ff, pr0_ff, pr1_ff;
   logic signed [2*DiffWidth-1:0] dl0_ff, dl1_ff;
   logic                          v1_ff;
   logic signed [DiffWidth-1:0] dly, dlx, drx, dry, dpx, dpy, drxc, dryc;
   // stage 2: edges and lanes
   lane_type left_ff, right_ff;
   tag_type  tag_ff;
   logic signed [EdgeWidth-1:0] el, er, dl, dr;
   logic [MagWidth-1:0] mel, mer, mdl, mdr;

   always_comb begin
      dly  = DiffWidth'(cy) - DiffWidth'(ly);
      dlx  = DiffWidth'(lx) - DiffWidth'(cx);
      dry  = DiffWidth'(cy) - DiffWidth'(ry);
      drx  = DiffWidth'(rx) - DiffWidth'(cx);
      dpx  = DiffWidth'(px) - DiffWidth'(cx);
      dpy  = DiffWidth'(py) - DiffWidth'(cy);
      drxc = DiffWidth'(rx) - DiffWidth'(cx);
      dryc = DiffWidth'(ry) - DiffWidth'(cy);
   end

   // register the products; right denominator is the negated left one
   always_ff @(posedge clock) begin
      pl0_ff <= dly * dpx;
      pl1_ff <= dlx * dpy;
      pr0_ff <= dry * dpx;
      pr1_ff <= drx * dpy;
      dl0_ff <= dly * drxc;
      dl1_ff <= dlx * dryc;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= go;
      end
   end

   always_comb begin
      el = EdgeWidth'(pl0_ff) + EdgeWidth'(pl1_ff);
      er = EdgeWidth'(pr0_ff) + EdgeWidth'(pr1_ff);
      dl = EdgeWidth'(dl0_ff) + EdgeWidth'(dl1_ff);
      dr = -dl;
      mel = el[EdgeWidth-1] ? MagWidth'(-el) : MagWidth'(el);
      mer = er[EdgeWidth-1] ? MagWidth'(-er) : MagWidth'(er);
      mdl = dl[EdgeWidth-1] ? MagWidth'(-dl) : MagWidth'(dl);
      mdr = dr[EdgeWidth-1] ? MagWidth'(-dr) : MagWidth'(dr);
   end

   // form rounded numerators and doubled denominators
   always_ff @(posedge clock) begin
      left_ff.num  <= {1'b0, mel, 17'd0} + NumWidth'(mdl);
      left_ff.rem  <= '0;
      left_ff.quo  <= '0;
      left_ff.den2 <= {1'b0, mdl, 1'b0};
      left_ff.neg  <= el[EdgeWidth-1] ^ dl[EdgeWidth-1];
      right_ff.num  <= {1'b0, mer, 17'd0} + NumWidth'(mdr);
      right_ff.rem  <= '0;
      right_ff.quo  <= '0;
      right_ff.den2 <= {1'b0, mdr, 1'b0};
      right_ff.neg  <= er[EdgeWidth-1] ^ dr[EdgeWidth-1];
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff.valid <= v1_ff;
         tag_ff.degen <= (dl == '0);
      end
   end

   assign left_out  = left_ff;
   assign right_out = right_ff;
   assign tag_out   = tag_ff;
endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import bary_pkg::*;

   localparam int LatencyCycles = NumCells + 8;
   localparam int CycleLimit    = 400000;
   localparam int NumVertRegs   = 6;
   localparam logic [RegIdxWidth-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [RegIdxWidth-1:0] REG_UNUSED_7 = 3'd7;
   localparam longint OneQ16 = 65536;

   typedef struct {
      logic signed [WeightWidth-1:0] w_opp;
      logic signed [WeightWidth-1:0] w_left;
      logic signed [WeightWidth-1:0] w_right;
      logic                          degen;
   } weights_type;

   logic clock, reset, start, busy;
   logic signed [CoordWidth-1:0] req_point_x, req_point_y;
   logic rsp_valid, rsp_degenerate;
   logic signed [WeightWidth-1:0] rsp_weight_opposite, rsp_weight_left, rsp_weight_right;
   logic csr_valid, csr_ready;
   logic [RegIdxWidth-1:0] csr_index;
   logic [CoordWidth-1:0] csr_data;

   // triangle as the block should hold it
   logic [CoordWidth-1:0] vertex_reg [NumVertRegs];
   weights_type pending_weights[$];
   int sender_idle_pct;
   int mismatch_count, points_sent, weights_checked, vertex_writes;
   int cycle_count;

   barycentric_2d_edge_function uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .rsp_valid(rsp_valid), .rsp_weight_opposite(rsp_weight_opposite),
      .rsp_weight_left(rsp_weight_left), .rsp_weight_right(rsp_weight_right),
      .rsp_degenerate(rsp_degenerate), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // line function of Q against the edge S-T, exact in 64 bits
   function automatic longint edge_value(longint sx, longint sy, longint tx, longint ty,
                                         longint qx, longint qy);
      return (sy - ty) * (qx - sx) + (tx - sx) * (qy - sy);
   endfunction

   // num/den in Q15.16, round half away from zero, saturate
   function automatic longint weight_q16(longint num, longint den);
      logic neg;
      longint unsigned an, ad, q;
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = ((an << 17) + ad) / (ad << 1);
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      if (!neg && q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint vert(logic [RegIdxWidth-1:0] idx);
      return longint'($signed(vertex_reg[idx]));
   endfunction

   function automatic weights_type barycentric_weights(logic signed [CoordWidth-1:0] px,
                                                       logic signed [CoordWidth-1:0] py);
      weights_type w;
      longint cx, cy, lx, ly, rx, ry, den_l, den_r, wl, wr, wo;
      cx = vert(REG_CENTER_X); cy = vert(REG_CENTER_Y);
      lx = vert(REG_LEFT_X);   ly = vert(REG_LEFT_Y);
      rx = vert(REG_RIGHT_X);  ry = vert(REG_RIGHT_Y);
      den_l = edge_value(cx, cy, lx, ly, rx, ry);
      den_r = edge_value(cx, cy, rx, ry, lx, ly);
      w = '{default: '0};
      if (den_l == 0 || den_r == 0) begin
         w.degen = 1'b1;
      end else begin
         wl = weight_q16(edge_value(cx, cy, lx, ly, longint'(px), longint'(py)), den_l);
         wr = weight_q16(edge_value(cx, cy, rx, ry, longint'(px), longint'(py)), den_r);
         wo = OneQ16 - wl - wr;
         if (wo > 64'sd2147483647) wo = 64'sd2147483647;
         if (wo < -64'sd2147483648) wo = -64'sd2147483648;
         w.w_left = wl[31:0];
         w.w_right = wr[31:0];
         w.w_opp = wo[31:0];
      end
      return w;
   endfunction

   // compare each response word against the oldest prediction
   always @(posedge clock) begin
      weights_type exp_w;
      if (!reset && rsp_valid) begin
         if (pending_weights.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response word at cycle %0d", cycle_count);
         end else begin
            exp_w = pending_weights.pop_front();
            weights_checked++;
            if (rsp_weight_opposite !== exp_w.w_opp || rsp_weight_left !== exp_w.w_left ||
                rsp_weight_right !== exp_w.w_right || rsp_degenerate !== exp_w.degen) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp opp=%0d left=%0d right=%0d degen=%0b, got %0d %0d %0d %0b",
                           exp_w.w_opp, exp_w.w_left, exp_w.w_right, exp_w.degen,
                           rsp_weight_opposite, rsp_weight_left, rsp_weight_right,
                           rsp_degenerate);
            end
         end
      end
   end

   // guard against a hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_point(logic signed [CoordWidth-1:0] px, logic signed [CoordWidth-1:0] py);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      // hold until the block takes the word
      do @(posedge clock); while (busy);
      pending_weights.push_back(barycentric_weights(px, py));
      points_sent++;
   endtask

   // drop start, wait for every prediction, then let the pipe drain
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_weights.size() != 0) @(posedge clock);
      repeat (LatencyCycles) @(posedge clock);
   endtask

   task automatic write_vertex(logic [RegIdxWidth-1:0] idx, logic [CoordWidth-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < NumVertRegs) vertex_reg[idx] = value;
      vertex_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_triangle(int cx, int cy, int lx, int ly, int rx, int ry);
      wait_idle();
      write_vertex(REG_CENTER_X, cx[15:0]);
      write_vertex(REG_CENTER_Y, cy[15:0]);
      write_vertex(REG_LEFT_X, lx[15:0]);
      write_vertex(REG_LEFT_Y, ly[15:0]);
      write_vertex(REG_RIGHT_X, rx[15:0]);
      write_vertex(REG_RIGHT_Y, ry[15:0]);
   endtask

   // reset triangle is all zero, so every weight must come back flagged
   task automatic test_reset_degenerate();
      send_point(16'sd0, 16'sd0);
      send_point(16'sh7FFF, -16'sh8000);
      set_triangle(0, 0, 100, 100, -200, -200);
      send_point(16'sd37, -16'sd5);
   endtask

   task automatic test_extremes();
      set_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
      send_point(16'sh7FFF, 16'sh7FFF);
      send_point(-16'sh8000, -16'sh8000);
      send_point(16'sh7FFF, -16'sh8000);
      send_point(-16'sh8000, 16'sh7FFF);
      send_point(16'sd0, 16'sd0);
      send_point(-16'sd1, 16'sd1);
   endtask

   // tiny triangle with far points drives the weights into both rails
   task automatic test_saturation();
      set_triangle(0, 0, 1, 0, 0, 1);
      send_point(16'sh7FFF, 16'sh7FFF);
      send_point(-16'sh8000, -16'sh8000);
      send_point(16'sh7FFF, -16'sh8000);
      send_point(-16'sh8000, 16'sh7FFF);
      send_point(16'sd1, 16'sd1);
   endtask

   // denominator of 2^17 with odd numerators lands exactly on half steps
   task automatic test_rounding_ties();
      set_triangle(0, 0, 512, 1, 0, 256);
      send_point(16'sd1, 16'sd0);
      send_point(-16'sd1, 16'sd0);
      send_point(16'sd3, 16'sd7);
      send_point(-16'sd5, -16'sd2);
   endtask

   // writes past the last vertex must leave the triangle alone
   task automatic test_unused_index();
      wait_idle();
      write_vertex(REG_UNUSED_6, 16'hFFFF);
      write_vertex(REG_UNUSED_7, 16'h5A5A);
      send_point(16'sd100, -16'sd100);
      send_point(16'sd256, 16'sd256);
   endtask

   function automatic int rand_coord(bit narrow);
      return narrow ? $urandom_range(1024) - 512 : $urandom_range(65535) - 32768;
   endfunction

   task automatic test_random(int num_triangles, int points_each);
      int cx, cy, lx, ly, rx, ry, k;
      bit narrow;
      for (int t = 0; t < num_triangles; t++) begin
         narrow = 1'($urandom_range(1));
         cx = rand_coord(narrow); cy = rand_coord(narrow);
         lx = rand_coord(narrow); ly = rand_coord(narrow);
         if ($urandom_range(7) == 0) begin
            // collinear corner: degenerate triangle
            k = $urandom_range(4) - 2;
            rx = cx + k * (lx - cx); ry = cy + k * (ly - cy);
         end else begin
            rx = rand_coord(narrow); ry = rand_coord(narrow);
         end
         set_triangle(cx, cy, lx, ly, rx, ry);
         for (int i = 0; i < points_each; i++) begin
            if ($urandom_range(1))
               send_point(16'($urandom_range(65535)), 16'($urandom_range(65535)));
            else
               send_point(16'(cx + $urandom_range(2048) - 1024),
                          16'(cy + $urandom_range(2048) - 1024));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      for (int i = 0; i < NumVertRegs; i++) vertex_reg[i] = '0;
      sender_idle_pct = 27;
      mismatch_count = 0;
      points_sent = 0;
      weights_checked = 0;
      vertex_writes = 0;
      cycle_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_degenerate();
      test_extremes();
      test_saturation();
      test_rounding_ties();
      test_unused_index();
      test_random(5, 70);
      sender_idle_pct = 51;
      test_random(5, 70);
      sender_idle_pct = 0;
      test_random(5, 70);

      wait_idle();
      $display("covered %0d points, %0d weight words checked, %0d register writes",
               points_sent, weights_checked, vertex_writes);
      $display("triangles: reset, extremes, tiny, tie rounding, collinear and random");
      if (mismatch_count == 0 && pending_weights.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// File: barycentric_2d_edge_function.f
design/bary_pkg.sv
design/bary_cell.sv
design/bary_front.sv
design/barycentric_2d_edge_function.sv
tb/testbench.sv
